FILE: src/assert_macros.svh
// Assertion macros shared by the strip charge-division position RTL.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define SCDP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define SCDP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: src/scdp_pkg.sv
// Package for the strip charge-division position block: codes, widths,
// the side-band struct carried through the divider, and saturation helper.
package scdp_pkg;

   localparam int NUM_DETECTORS_DEF = 16;
   localparam int NUM_STRIPS_DEF    = 8;
   localparam int ENERGY_BITS_DEF   = 16;
   localparam int QUOT_W            = 16;
   localparam int SUM_W             = 17;
   localparam int VAL_W             = 32;
   localparam int NUM_SLOTS         = 3;
   localparam logic [4:0] SPLIT_RESET = 5'd6;
   localparam logic signed [7:0] Z_SCALE = 8'sd75;

   typedef enum logic [1:0] {
      CMD_HIT      = 2'd0,
      CMD_WR_CAL   = 2'd1,
      CMD_WR_COORD = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   localparam logic [1:0] SLOT_INVALID = 2'd3;

   typedef struct packed {
      logic                    neg;
      logic                    zero;
      logic [3:0]              det;
      logic [SUM_W-1:0]        sum;
      logic signed [VAL_W-1:0] c0;
      logic signed [VAL_W-1:0] c1;
      logic signed [VAL_W-1:0] c2;
      logic signed [VAL_W-1:0] tx;
      logic signed [VAL_W-1:0] ty;
      logic signed [VAL_W-1:0] tz;
   } hit_side_type;

   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end else begin
         return v[VAL_W-1:0];
      end
   endfunction

endpackage

FILE: src/scdp_tables.sv
// Calibration and strip coordinate memories, one row of three lanes per strip.
// Depends on scdp_pkg; one lane write and one row read per cycle, read registered.
module scdp_tables #(
   parameter int ROWS  = scdp_pkg::NUM_DETECTORS_DEF * scdp_pkg::NUM_STRIPS_DEF,
   parameter int ROW_W = 7
) (
   input  logic                          clock,
   input  logic                          wr_cal,
   input  logic                          wr_coord,
   input  logic [ROW_W-1:0]              wr_row,
   input  logic [1:0]                    wr_slot,
   input  logic signed [scdp_pkg::VAL_W-1:0] wr_value,
   input  logic                          rd_en,
   input  logic [ROW_W-1:0]              rd_row,
   output logic [scdp_pkg::NUM_SLOTS-1:0][scdp_pkg::VAL_W-1:0] cal_row,
   output logic [scdp_pkg::NUM_SLOTS-1:0][scdp_pkg::VAL_W-1:0] coord_row
);
   import scdp_pkg::*;

   logic [NUM_SLOTS-1:0][VAL_W-1:0] cal_mem   [ROWS];
   logic [NUM_SLOTS-1:0][VAL_W-1:0] coord_mem [ROWS];

   always_ff @(posedge clock) begin
      if (wr_cal) begin
         cal_mem[wr_row][wr_slot] <= wr_value;
      end
      if (wr_coord) begin
         coord_mem[wr_row][wr_slot] <= wr_value;
      end
      if (rd_en) begin
         cal_row   <= cal_mem[rd_row];
         coord_row <= coord_mem[rd_row];
      end
   end

endmodule

FILE: src/scdp_divider.sv
// Pipelined restoring divider, one quotient bit per stage, side band carried along.
// Depends on scdp_pkg for the quotient width and the side-band struct.
module scdp_divider #(
   parameter int RW = scdp_pkg::ENERGY_BITS_DEF + 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [RW-1:0]                 dividend,
   input  logic [RW-1:0]                 divisor,
   input  scdp_pkg::hit_side_type        in_side,
   output logic                          out_valid,
   output logic [scdp_pkg::QUOT_W-1:0]   out_quot,
   output scdp_pkg::hit_side_type        out_side
);
   import scdp_pkg::*;

   logic              v_ff    [QUOT_W];
   logic [RW-1:0]     rem_ff  [QUOT_W];
   logic [RW-1:0]     dvs_ff  [QUOT_W];
   logic [QUOT_W-1:0] q_ff    [QUOT_W];
   hit_side_type      side_ff [QUOT_W];

   for (genvar s = 0; s < QUOT_W; s++) begin : g_stage
      logic              v_prev;
      logic [RW-1:0]     rem_prev;
      logic [RW-1:0]     dvs_prev;
      logic [QUOT_W-1:0] q_prev;
      hit_side_type      side_prev;
      logic [RW-1:0]     trial;
      logic              take;
      logic [RW-1:0]     rem_in;
      logic [QUOT_W-1:0] q_in;

      if (s == 0) begin : g_first
         assign v_prev    = in_valid;
         assign rem_prev  = dividend;
         assign dvs_prev  = divisor;
         assign q_prev    = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign v_prev    = v_ff[s-1];
         assign rem_prev  = rem_ff[s-1];
         assign dvs_prev  = dvs_ff[s-1];
         assign q_prev    = q_ff[s-1];
         assign side_prev = side_ff[s-1];
      end

      // quotient bit QUOT_W-1-s is decided here
      always_comb begin
         trial  = dvs_prev << (QUOT_W - 1 - s);
         take   = rem_prev >= trial;
         rem_in = take ? rem_prev - trial : rem_prev;
         q_in   = q_prev;
         q_in[QUOT_W-1-s] = take;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (en) begin
            v_ff[s] <= v_prev;
         end
         if (en) begin
            rem_ff[s]  <= rem_in;
            dvs_ff[s]  <= dvs_prev;
            q_ff[s]    <= q_in;
            side_ff[s] <= side_prev;
         end
      end
   end

   assign out_valid = v_ff[QUOT_W-1];
   assign out_quot  = q_ff[QUOT_W-1];
   assign out_side  = side_ff[QUOT_W-1];

endmodule

FILE: src/scdp_calc.sv
// Quadratic position correction, z placement and the output register.
// Depends on scdp_pkg; fed by the divider quotient and side band.
module scdp_calc (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [scdp_pkg::QUOT_W-1:0]     in_quot,
   input  scdp_pkg::hit_side_type          in_side,
   input  logic [4:0]                      split,
   output logic                            out_valid,
   output logic                            out_flag,
   output logic [scdp_pkg::SUM_W-1:0]      out_sum,
   output logic signed [scdp_pkg::VAL_W-1:0] out_pos,
   output logic signed [scdp_pkg::VAL_W-1:0] out_x,
   output logic signed [scdp_pkg::VAL_W-1:0] out_y,
   output logic signed [scdp_pkg::VAL_W-1:0] out_z
);
   import scdp_pkg::*;

   // stage 1: c1*r and r*r
   logic               v1_ff;
   hit_side_type       s1_ff;
   logic signed [48:0] c1r_ff;
   logic [31:0]        rr_ff;
   // stage 2: c2*r*r
   logic               v2_ff;
   hit_side_type       s2_ff;
   logic signed [48:0] c1r2_ff;
   logic signed [63:0] c2rr_ff;
   // stage 3: position
   logic               v3_ff;
   hit_side_type       s3_ff;
   logic signed [31:0] pos_ff;
   // stage 4: 75*position
   logic               v4_ff;
   hit_side_type       s4_ff;
   logic signed [31:0] pos4_ff;
   logic signed [39:0] p75_ff;
   // output
   logic               ov_ff;
   logic               flag_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic signed [31:0] pos_o_ff, x_ff, y_ff, z_ff;

   logic signed [16:0] r_in;
   logic signed [63:0] acc_in;
   logic signed [33:0] acc_sh;
   logic signed [40:0] z2_in;
   logic signed [39:0] z_sh;
   logic               mirror;

   always_comb begin
      r_in   = in_side.neg ? -$signed({1'b0, in_quot}) : $signed({1'b0, in_quot});
      acc_in = ({{32{s2_ff.c0[31]}}, s2_ff.c0} <<< 30)
             + ({{15{c1r2_ff[48]}}, c1r2_ff} <<< 15)
             + c2rr_ff;
      acc_sh = acc_in[63:30];
      mirror = {1'b0, s4_ff.det} >= split;
      z2_in  = mirror ? ({{8{s4_ff.tz[31]}}, s4_ff.tz, 1'b0} + {p75_ff[39], p75_ff})
                      : ({{8{s4_ff.tz[31]}}, s4_ff.tz, 1'b0} - {p75_ff[39], p75_ff});
      z_sh   = z2_in[40:1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         ov_ff <= v4_ff;
      end
      if (en) begin
         s1_ff   <= in_side;
         c1r_ff  <= in_side.c1 * r_in;
         rr_ff   <= in_quot * in_quot;
         s2_ff   <= s1_ff;
         c1r2_ff <= c1r_ff;
         c2rr_ff <= s1_ff.c2 * $signed({1'b0, rr_ff[30:0]});
         s3_ff   <= s2_ff;
         pos_ff  <= sat32({{30{acc_sh[33]}}, acc_sh});
         s4_ff   <= s3_ff;
         pos4_ff <= pos_ff;
         p75_ff  <= pos_ff * Z_SCALE;
         // a zero energy sum clears everything but the sum
         flag_ff  <= !s4_ff.zero;
         sum_ff   <= s4_ff.sum;
         pos_o_ff <= s4_ff.zero ? '0 : pos4_ff;
         x_ff     <= s4_ff.zero ? '0 : s4_ff.tx;
         y_ff     <= s4_ff.zero ? '0 : s4_ff.ty;
         z_ff     <= s4_ff.zero ? '0 : sat32({{24{z_sh[39]}}, z_sh});
      end
   end

   assign out_valid = ov_ff;
   assign out_flag  = flag_ff;
   assign out_sum   = sum_ff;
   assign out_pos   = pos_o_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

FILE: src/strip_charge_division_position.sv
// Strip charge-division position: table lookup, pipelined ratio divider, correction.
// Hit path: input register and table read, divider stages, calc stages, output register, then rsp_tvalid.
// Throughput: one beat per cycle; the whole pipeline holds while the result waits.
// Table writes produce no result and land in the memory at the accepting edge.
// Synchronous reset clears pipeline valids and sets the mirror split to 6;
// table contents are undefined until written, no clearing pass.
`include "assert_macros.svh"

module strip_charge_division_position #(
   parameter int NUM_DETECTORS = scdp_pkg::NUM_DETECTORS_DEF,
   parameter int NUM_STRIPS    = scdp_pkg::NUM_STRIPS_DEF,
   parameter int ENERGY_BITS   = scdp_pkg::ENERGY_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // detector[3:0] strip[6:4] energy_up[22:7] energy_down[38:23]
   // table_slot[40:39] table_value[72:41], zero fill above
   input  logic [79:0]  req_tdata,
   // command[1:0]
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // energy_sum[16:0] calibrated_position[48:17] coord_x[80:49]
   // coord_y[112:81] coord_z[144:113], zero fill above
   output logic [151:0] rsp_tdata,
   // valid_res[0]
   output logic [0:0]   rsp_tuser,
   input  logic         csr_we,
   input  logic [4:0]   csr_wdata
);
   import scdp_pkg::*;

   localparam int ROWS  = NUM_DETECTORS * NUM_STRIPS;
   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int EU_W  = (ENERGY_BITS < 16) ? ENERGY_BITS : 16;
   localparam int RW    = EU_W + QUOT_W;

   logic [3:0]              in_det;
   logic [2:0]              in_strip;
   logic [15:0]             in_eu, in_ed;
   logic [1:0]              in_slot;
   logic signed [VAL_W-1:0] in_value;
   cmd_type                 in_cmd;

   logic               adv, accept, in_range;
   logic [ROW_W-1:0]   row;
   logic [EU_W-1:0]    eu, ed;
   logic [EU_W:0]      sum, mag;
   logic               slot_ok;

   logic [4:0]         split_ff;
   logic               d0_v_ff, d0_neg_ff, d0_zero_ff, d0_inr_ff;
   logic [3:0]         d0_det_ff;
   logic [EU_W:0]      d0_sum_ff, d0_mag_ff;

   logic [NUM_SLOTS-1:0][VAL_W-1:0] cal_row, coord_row;
   hit_side_type       side;
   logic               dv_valid;
   logic [QUOT_W-1:0]  dv_quot;
   hit_side_type       dv_side;
   logic               o_flag;
   logic [SUM_W-1:0]   o_sum;
   logic signed [VAL_W-1:0] o_pos, o_x, o_y, o_z;

   always_comb begin
      in_det   = req_tdata[3:0];
      in_strip = req_tdata[6:4];
      in_eu    = req_tdata[22:7];
      in_ed    = req_tdata[38:23];
      in_slot  = req_tdata[40:39];
      in_value = req_tdata[72:41];
      in_cmd   = cmd_type'(req_tuser);
      adv      = !rsp_tvalid || rsp_tready;
      accept   = req_tvalid && adv;
      in_range = (32'(in_det) < NUM_DETECTORS) && (32'(in_strip) < NUM_STRIPS);
      slot_ok  = in_slot != SLOT_INVALID;
      row      = ROW_W'(32'(in_det) * NUM_STRIPS + 32'(in_strip));
      eu       = in_eu[EU_W-1:0];
      ed       = in_ed[EU_W-1:0];
      sum      = {1'b0, eu} + {1'b0, ed};
      mag      = (eu >= ed) ? {1'b0, eu} - {1'b0, ed} : {1'b0, ed} - {1'b0, eu};
   end

   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         split_ff <= SPLIT_RESET;
         d0_v_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            split_ff <= csr_wdata;
         end
         if (adv) begin
            d0_v_ff <= accept && (in_cmd == CMD_HIT);
         end
      end
      if (adv) begin
         d0_neg_ff  <= ed > eu;
         d0_zero_ff <= sum == '0;
         d0_inr_ff  <= in_range;
         d0_det_ff  <= in_det;
         d0_sum_ff  <= sum;
         d0_mag_ff  <= mag;
      end
   end

   scdp_tables #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
   ) u_tables (
      .clock     (clock),
      .wr_cal    (accept && in_cmd == CMD_WR_CAL && in_range && slot_ok),
      .wr_coord  (accept && in_cmd == CMD_WR_COORD && in_range && slot_ok),
      .wr_row    (row),
      .wr_slot   (in_slot),
      .wr_value  (in_value),
      .rd_en     (adv),
      .rd_row    (row),
      .cal_row   (cal_row),
      .coord_row (coord_row)
   );

   // out-of-range hits read zero for every coefficient and coordinate
   always_comb begin
      side.neg  = d0_neg_ff;
      side.zero = d0_zero_ff;
      side.det  = d0_det_ff;
      side.sum  = SUM_W'(d0_sum_ff);
      side.c0   = d0_inr_ff ? cal_row[0]   : '0;
      side.c1   = d0_inr_ff ? cal_row[1]   : '0;
      side.c2   = d0_inr_ff ? cal_row[2]   : '0;
      side.tx   = d0_inr_ff ? coord_row[0] : '0;
      side.ty   = d0_inr_ff ? coord_row[1] : '0;
      side.tz   = d0_inr_ff ? coord_row[2] : '0;
   end

   scdp_divider #(
      .RW (RW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (d0_v_ff),
      .dividend  (RW'({d0_mag_ff, 15'd0})),
      .divisor   (RW'(d0_sum_ff)),
      .in_side   (side),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_side  (dv_side)
   );

   scdp_calc u_calc (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (dv_valid),
      .in_quot   (dv_quot),
      .in_side   (dv_side),
      .split     (split_ff),
      .out_valid (rsp_tvalid),
      .out_flag  (o_flag),
      .out_sum   (o_sum),
      .out_pos   (o_pos),
      .out_x     (o_x),
      .out_y     (o_y),
      .out_z     (o_z)
   );

   assign rsp_tdata = {7'd0, o_z, o_y, o_x, o_pos, o_sum};
   assign rsp_tuser = o_flag;

   `SCDP_ASSERT(a_ready_when_empty, clock, reset, !rsp_tvalid |-> req_tready, "ready low with empty output")
   `SCDP_ASSERT(a_ratio_bound, clock, reset, (dv_valid && !dv_side.zero) |-> (dv_quot <= 16'h8000), "ratio above one")
   `SCDP_ASSERT(a_zero_sum_clear, clock, reset, (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[144:17] == '0), "zero-sum result not cleared")

endmodule

FILE: tb/tb_strip_charge_division_position.sv
`timescale 1ns / 1ps
// Self-checking testbench for strip_charge_division_position: writes both tables,
// sends hits with random gaps and result stalls, and compares every result beat.
// Depends on scdp_pkg and the RTL only.

class position_scoreboard;
   typedef struct {
      logic        valid_res;
      logic [16:0] energy_sum;
      logic [31:0] position;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
   } hit_result_type;

   logic signed [31:0] cal_coef[384];
   logic signed [31:0] strip_coord[384];
   bit                 cal_written[384];
   bit                 coord_written[384];
   logic [4:0]         split;
   hit_result_type     pending_hits[$];
   int                 errors;

   function new();
      split = scdp_pkg::SPLIT_RESET;
      errors = 0;
   endfunction

   function bit strip_loaded(int det, int strip);
      int base;
      base = (det * 8 + strip) * 3;
      for (int k = 0; k < 3; k++) begin
         if (!cal_written[base + k] || !coord_written[base + k]) return 0;
      end
      return 1;
   endfunction

   function longint signed clamp32(longint signed v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Work out the result of an accepted beat, or update the tables.
   function void note_beat(scdp_pkg::cmd_type cmd, logic [3:0] det, logic [2:0] strip,
                           logic [15:0] eu, logic [15:0] ed, logic [1:0] slot,
                           logic signed [31:0] value);
      int                 base;
      hit_result_type     res;
      longint signed      diff, r, acc, pos, z2;
      longint unsigned    mag, sum;
      base = (det * 8 + strip) * 3;
      if (cmd == scdp_pkg::CMD_WR_CAL || cmd == scdp_pkg::CMD_WR_COORD) begin
         if (slot != scdp_pkg::SLOT_INVALID) begin
            if (cmd == scdp_pkg::CMD_WR_CAL) begin
               cal_coef[base + slot] = value;
               cal_written[base + slot] = 1;
            end else begin
               strip_coord[base + slot] = value;
               coord_written[base + slot] = 1;
            end
         end
         return;
      end
      if (cmd != scdp_pkg::CMD_HIT) return;
      sum = longint'(eu) + longint'(ed);
      res = '{1'b0, sum[16:0], 32'd0, 32'd0, 32'd0, 32'd0};
      if (sum != 0) begin
         diff = longint'(eu) - longint'(ed);
         mag = ((diff < 0 ? -diff : diff) << 15) / sum;
         r = diff < 0 ? -longint'(mag) : longint'(mag);
         acc = longint'(cal_coef[base]) * (64'sd1 << 30)
             + longint'(cal_coef[base + 1]) * r * (64'sd1 << 15)
             + longint'(cal_coef[base + 2]) * (r * r);
         pos = clamp32(acc >>> 30);
         if (det < split) z2 = longint'(strip_coord[base + 2]) * 2 - pos * 75;
         else z2 = longint'(strip_coord[base + 2]) * 2 + pos * 75;
         res.valid_res = 1'b1;
         res.position = pos[31:0];
         res.x = strip_coord[base];
         res.y = strip_coord[base + 1];
         res.z = 32'(clamp32(z2 >>> 1));
      end
      pending_hits.insert(pending_hits.size(), res);
   endfunction

   function void check_beat(logic [0:0] tuser, logic [151:0] tdata);
      hit_result_type e;
      if (pending_hits.size() == 0) begin
         $error("result beat with nothing expected");
         errors++;
         return;
      end
      e = pending_hits.pop_front();
      if (tuser[0] !== e.valid_res) begin
         $error("valid_res exp %0d got %0d", e.valid_res, tuser[0]); errors++;
      end
      if (tdata[16:0] !== e.energy_sum) begin
         $error("energy_sum exp %0d got %0d", e.energy_sum, tdata[16:0]); errors++;
      end
      if (tdata[48:17] !== e.position) begin
         $error("calibrated_position exp %h got %h", e.position, tdata[48:17]); errors++;
      end
      if (tdata[80:49] !== e.x) begin
         $error("coord_x exp %h got %h", e.x, tdata[80:49]); errors++;
      end
      if (tdata[112:81] !== e.y) begin
         $error("coord_y exp %h got %h", e.y, tdata[112:81]); errors++;
      end
      if (tdata[144:113] !== e.z) begin
         $error("coord_z exp %h got %h", e.z, tdata[144:113]); errors++;
      end
      if (tdata[151:145] !== 7'd0) begin
         $error("rsp_tdata fill exp 0 got %h", tdata[151:145]); errors++;
      end
   endfunction
endclass

module tb_strip_charge_division_position;
   import scdp_pkg::*;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [79:0]  req_tdata;
   logic [1:0]   req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [151:0] rsp_tdata;
   logic [0:0]   rsp_tuser;
   logic         csr_we;
   logic [4:0]   csr_wdata;

   position_scoreboard positions;
   bit                 rsp_stalls;
   bit                 req_gaps;

   strip_charge_division_position u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("status: fail");
      $finish;
   end

   function automatic int gap_length();
      if ($urandom_range(9) < 6) return 0;
      if ($urandom_range(9) < 8) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: random back-pressure while enabled.
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         rsp_tready <= 1'b1;
         n = rsp_stalls ? gap_length() : 0;
         if (n > 0) begin
            @(posedge clock);
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) positions.check_beat(rsp_tuser, rsp_tdata);
   end

   // Drive one beat and hold it until accepted; the caller is at a clock edge.
   task automatic send_beat(cmd_type cmd, logic [3:0] det, logic [2:0] strip,
                            logic [15:0] eu, logic [15:0] ed, logic [1:0] slot,
                            logic [31:0] value);
      int n;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, value, slot, ed, eu, strip, det};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      positions.note_beat(cmd, det, strip, eu, ed, slot, value);
      n = req_gaps ? gap_length() : 0;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic drain_and_set_split(logic [4:0] value);
      req_tvalid <= 1'b0;
      while (positions.pending_hits.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      positions.split = value;
      @(posedge clock);
   endtask

   function automatic logic [31:0] table_value();
      case ($urandom_range(5))
         0: return $urandom();
         1: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
         2: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      endcase
   endfunction

   task automatic random_hit();
      logic [3:0]  det;
      logic [2:0]  strip;
      logic [15:0] eu, ed;
      do begin
         det = 4'($urandom());
         strip = 3'($urandom());
      end while (!positions.strip_loaded(det, strip));
      eu = 16'($urandom());
      ed = 16'($urandom());
      case ($urandom_range(9))
         0: ed = 16'd0;
         1: eu = 16'd0;
         2: ed = eu;
         3: begin eu = 16'd0; ed = 16'd0; end
         4: begin eu = 16'($urandom_range(0, 15)); ed = 16'($urandom_range(0, 15)); end
         default: ;
      endcase
      send_beat(CMD_HIT, det, strip, eu, ed, 2'($urandom()), $urandom());
   endtask

   task automatic random_phase(int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < 55 && positions.strip_loaded(0, 0)) random_hit();
         else if (pick < 75)
            send_beat(CMD_WR_CAL, 4'($urandom()), 3'($urandom()), 16'($urandom()),
                      16'($urandom()), 2'($urandom_range(2)), table_value());
         else if (pick < 95)
            send_beat(CMD_WR_COORD, 4'($urandom()), 3'($urandom()), 16'($urandom()),
                      16'($urandom()), 2'($urandom_range(2)), table_value());
         else if (pick < 97)
            send_beat(CMD_NONE, 4'($urandom()), 3'($urandom()), 16'($urandom()),
                      16'($urandom()), 2'($urandom()), $urandom());
         else
            send_beat(cmd_type'($urandom_range(1, 2)), 4'($urandom()), 3'($urandom()),
                      16'($urandom()), 16'($urandom()), SLOT_INVALID, $urandom());
      end
   endtask

   initial begin
      int          waited;
      logic [4:0]  splits[5];
      positions  = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_HIT;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      rsp_stalls = 1'b0;
      req_gaps   = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: load two strips at the corners, then the edge cases.
      for (int k = 0; k < 3; k++) begin
         send_beat(CMD_WR_CAL, 4'd0, 3'd0, 16'd0, 16'd0, 2'(k),
                   k == 1 ? 32'h0001_0000 : 32'd0);
         send_beat(CMD_WR_COORD, 4'd0, 3'd0, 16'd0, 16'd0, 2'(k),
                   32'(32'h0005_0000 * (k + 1)));
         send_beat(CMD_WR_CAL, 4'd15, 3'd7, 16'hFFFF, 16'hFFFF, 2'(k),
                   k == 0 ? 32'h7FFFFFFF : 32'h80000000);
         send_beat(CMD_WR_COORD, 4'd15, 3'd7, 16'hFFFF, 16'hFFFF, 2'(k),
                   k == 2 ? 32'h80000000 : 32'h7FFFFFFF);
      end
      send_beat(CMD_HIT, 4'd0, 3'd0, 16'd0, 16'd0, 2'd0, 32'd0);           // zero sum
      send_beat(CMD_HIT, 4'd0, 3'd0, 16'hFFFF, 16'd0, 2'd0, 32'd0);        // ratio at +1
      send_beat(CMD_HIT, 4'd0, 3'd0, 16'd0, 16'hFFFF, 2'd0, 32'd0);        // ratio at -1
      send_beat(CMD_HIT, 4'd0, 3'd0, 16'h1234, 16'h1234, 2'd0, 32'd0);     // centre
      send_beat(CMD_HIT, 4'd15, 3'd7, 16'hFFFF, 16'hFFFF, 2'd3, 32'hFFFFFFFF);
      send_beat(CMD_HIT, 4'd15, 3'd7, 16'hFFFF, 16'd1, 2'd0, 32'd0);       // saturate both ways
      send_beat(CMD_NONE, 4'd0, 3'd0, 16'hFFFF, 16'hFFFF, 2'd0, 32'hFFFFFFFF);
      send_beat(CMD_WR_CAL, 4'd0, 3'd0, 16'd0, 16'd0, SLOT_INVALID, 32'h7FFFFFFF);
      send_beat(CMD_HIT, 4'd0, 3'd0, 16'h0001, 16'h0003, 2'd0, 32'd0);

      splits = '{5'd0, 5'd16, 5'($urandom_range(1, 15)), 5'($urandom_range(0, 16)), 5'd6};
      for (int p = 0; p < 5; p++) begin
         drain_and_set_split(splits[p]);
         rsp_stalls = (p != 1);
         req_gaps   = (p != 3);
         random_phase(265);
      end

      req_tvalid <= 1'b0;
      waited = 0;
      while (positions.pending_hits.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (40) @(posedge clock);
      if (positions.errors == 0 && positions.pending_hits.size() == 0) begin
         $display("status: pass");
      end else begin
         if (positions.pending_hits.size() != 0)
            $error("%0d results never arrived", positions.pending_hits.size());
         $display("status: fail");
      end
      $finish;
   end
endmodule

FILE: files.f
+incdir+src
src/scdp_pkg.sv
src/scdp_tables.sv
src/scdp_divider.sv
src/scdp_calc.sv
src/strip_charge_division_position.sv
tb/tb_strip_charge_division_position.sv
